// ===== rtl/rsa_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
// Used by rsa_stack, rsa_alu and rpn_stack_alu; depends on nothing.
`default_nettype none

package rsa_pkg;

    localparam int DATA_W      = 32;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int STACK_DEPTH = 4;

    localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FEW     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd3;

    typedef struct packed {
        logic              push;
        logic              drop;
        logic [DATA_W-1:0] value;
    } stack_ctrl_t;

    typedef struct packed {
        logic              start;
        logic [MODE_W-1:0] op;
    } alu_req_t;

endpackage

`default_nettype wire

// ===== rtl/rsa_stack.sv =====
// Operand stack: X at entry 0, deepest entry last; push shifts up, drop shifts down.
// Depends on rsa_pkg.
`default_nettype none

module rsa_stack #(
    parameter int DEPTH = rsa_pkg::STACK_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire rsa_pkg::stack_ctrl_t       ctrl,
    output logic [rsa_pkg::DATA_W-1:0]      top,
    output logic [rsa_pkg::DATA_W-1:0]      second,
    output logic [rsa_pkg::DATA_W-1:0]      deepest
);

    logic [rsa_pkg::DATA_W-1:0] entry_reg  [DEPTH];
    logic [rsa_pkg::DATA_W-1:0] entry_next [DEPTH];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
        end
        if (ctrl.push) begin
            for (int i = 1; i < DEPTH; i++) begin
                entry_next[i] = entry_reg[i-1];
            end
            entry_next[0] = ctrl.value;
        end else if (ctrl.drop) begin
            // keep the deepest entry
            for (int i = 1; i < DEPTH - 1; i++) begin
                entry_next[i] = entry_reg[i+1];
            end
            entry_next[0] = ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                entry_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    assign top     = entry_reg[0];
    assign second  = entry_reg[1];
    assign deepest = entry_reg[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/rsa_alu.sv =====
// Iterative ALU around one shared 33-bit adder: add, subtract, shift-add multiply,
// restoring divide with sign fix-up. Depends on rsa_pkg.
`default_nettype none

module rsa_alu (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire rsa_pkg::alu_req_t          req,
    input  wire logic [rsa_pkg::DATA_W-1:0] y_in,
    input  wire logic [rsa_pkg::DATA_W-1:0] x_in,
    output logic                            done,
    output logic [rsa_pkg::DATA_W-1:0]      result
);

    localparam int W     = rsa_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    typedef enum logic [6:0] {
        P_IDLE = 7'b0000001,
        P_ONE  = 7'b0000010,
        P_ABSB = 7'b0000100,
        P_ABSA = 7'b0001000,
        P_LOOP = 7'b0010000,
        P_NEGQ = 7'b0100000,
        P_DONE = 7'b1000000
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [rsa_pkg::MODE_W-1:0] op_reg, op_next;
    logic [W-1:0]               a_reg, a_next;
    logic [W-1:0]               b_reg, b_next;
    logic [W-1:0]               acc_reg, acc_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       neg_reg, neg_next;

    logic [W:0] add_a, add_b, sum;
    logic       add_sub;
    logic       is_div;

    assign is_div = (op_reg == rsa_pkg::MODE_DIV);

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (phase_reg)
            P_ONE: begin
                add_a   = {1'b0, b_reg};
                add_b   = {1'b0, a_reg};
                add_sub = (op_reg == rsa_pkg::MODE_SUB);
            end
            P_LOOP: begin
                add_b = {1'b0, a_reg};
                if (is_div) begin
                    add_a   = {acc_reg, b_reg[W-1]};
                    add_sub = 1'b1;
                end else begin
                    add_a = {1'b0, acc_reg};
                end
            end
            P_ABSB, P_NEGQ: begin
                add_b   = {1'b0, b_reg};
                add_sub = 1'b1;
            end
            P_ABSA: begin
                add_b   = {1'b0, a_reg};
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
        sum = add_a + (add_b ^ {(W+1){add_sub}}) + {{W{1'b0}}, add_sub};
    end

    always_comb begin
        phase_next = phase_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        case (phase_reg)
            P_IDLE: begin
                if (req.start) begin
                    op_next  = req.op;
                    acc_next = '0;
                    cnt_next = '0;
                    a_next   = x_in;
                    b_next   = y_in;
                    neg_next = x_in[W-1] ^ y_in[W-1];
                    if (req.op == rsa_pkg::MODE_MUL) begin
                        a_next     = y_in;
                        b_next     = x_in;
                        phase_next = P_LOOP;
                    end else if (req.op == rsa_pkg::MODE_DIV) begin
                        phase_next = P_ABSB;
                    end else begin
                        phase_next = P_ONE;
                    end
                end
            end
            P_ONE: begin
                acc_next   = sum[W-1:0];
                phase_next = P_DONE;
            end
            P_ABSB: begin
                if (b_reg[W-1]) begin
                    b_next = sum[W-1:0];
                end
                phase_next = P_ABSA;
            end
            P_ABSA: begin
                if (a_reg[W-1]) begin
                    a_next = sum[W-1:0];
                end
                phase_next = P_LOOP;
            end
            P_LOOP: begin
                if (is_div) begin
                    acc_next = sum[W] ? add_a[W-1:0] : sum[W-1:0];
                    b_next   = {b_reg[W-2:0], ~sum[W]};
                end else begin
                    if (b_reg[0]) begin
                        acc_next = sum[W-1:0];
                    end
                    a_next = {a_reg[W-2:0], 1'b0};
                    b_next = {1'b0, b_reg[W-1:1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    phase_next = is_div ? P_NEGQ : P_DONE;
                end
            end
            P_NEGQ: begin
                if (neg_reg) begin
                    b_next = sum[W-1:0];
                end
                phase_next = P_DONE;
            end
            P_DONE: begin
                phase_next = P_IDLE;
            end
            default: begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign done   = (phase_reg == P_DONE);
    assign result = is_div ? b_reg : acc_reg;

endmodule

`default_nettype wire

// ===== rtl/rpn_stack_alu.sv =====
// RPN stack calculator top level: sequencer, operand stack and iterative ALU.
// Depends on rsa_pkg, rsa_stack and rsa_alu.
//
// Usage:
//   Input beats carry s_mode (push, add, subtract, multiply, divide) and
//   s_operand; each beat yields exactly one result beat carrying m_status,
//   m_top_value (X) and m_second_value (Y) after the step.
//   Arithmetic computes Y op X, drops the stack and places the result in X.
//   ALU work per step:
//     push, refused or invalid step   none
//     add, subtract                   one adder pass
//     multiply                        32 shift-add steps
//     divide                          two sign steps, 32 quotient steps, one sign fix-up
//   One beat is processed at a time; s_ready rises at the edge that loads the
//   result, and every arithmetic step runs on the single shared adder in the ALU.
//   The result register decouples the sides: a new beat is taken while the
//   previous result waits, and the block holds its finished result until
//   m_ready frees the output register.
//   Reset clears the stack to zero and empties the output register.
`default_nettype none

module rpn_stack_alu #(
    parameter int STACK_DEPTH = rsa_pkg::STACK_DEPTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rsa_pkg::MODE_W-1:0]          s_mode,
    input  wire logic signed [rsa_pkg::DATA_W-1:0]   s_operand,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [rsa_pkg::STATUS_W-1:0]             m_status,
    output logic signed [rsa_pkg::DATA_W-1:0]        m_top_value,
    output logic signed [rsa_pkg::DATA_W-1:0]        m_second_value
);

    localparam int W = rsa_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_RUN    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [rsa_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [W-1:0]                 operand_reg, operand_next;
    logic [rsa_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                         m_valid_reg, m_valid_next;
    logic [rsa_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [W-1:0]                 m_top_reg, m_top_next;
    logic [W-1:0]                 m_second_reg, m_second_next;

    rsa_pkg::stack_ctrl_t stack_ctrl;
    rsa_pkg::alu_req_t    alu_req;
    logic [W-1:0]         stack_top, stack_second, stack_deepest;
    logic                 alu_done;
    logic [W-1:0]         alu_result;
    logic                 s_beat, out_free;

    rsa_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (stack_ctrl),
        .top     (stack_top),
        .second  (stack_second),
        .deepest (stack_deepest)
    );

    rsa_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .y_in    (stack_second),
        .x_in    (stack_top),
        .done    (alu_done),
        .result  (alu_result)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_beat   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        operand_next  = operand_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_top_next    = m_top_reg;
        m_second_next = m_second_reg;
        stack_ctrl    = '{push: 1'b0, drop: 1'b0, value: operand_reg};
        alu_req       = '{start: 1'b0, op: mode_reg};
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    mode_next    = s_mode;
                    operand_next = $unsigned(s_operand);
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next  = ST_FINISH;
                status_next = rsa_pkg::STATUS_OK;
                if (mode_reg == rsa_pkg::MODE_PUSH) begin
                    if (stack_deepest != '0) begin
                        status_next = rsa_pkg::STATUS_FULL;
                    end else begin
                        stack_ctrl.push = 1'b1;
                    end
                end else if (stack_top == '0 || stack_second == '0) begin
                    status_next = rsa_pkg::STATUS_FEW;
                end else if (mode_reg == rsa_pkg::MODE_ADD || mode_reg == rsa_pkg::MODE_SUB
                             || mode_reg == rsa_pkg::MODE_MUL
                             || mode_reg == rsa_pkg::MODE_DIV) begin
                    alu_req.start = 1'b1;
                    state_next    = ST_RUN;
                end else begin
                    status_next = rsa_pkg::STATUS_INVALID;
                end
            end
            ST_RUN: begin
                if (alu_done) begin
                    stack_ctrl.drop  = 1'b1;
                    stack_ctrl.value = alu_result;
                    state_next       = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_top_next    = stack_top;
                    m_second_next = stack_second;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg     <= mode_next;
        operand_reg  <= operand_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_top_reg    <= m_top_next;
        m_second_reg <= m_second_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_top_value    = $signed(m_top_reg);
    assign m_second_value = $signed(m_second_reg);

`ifndef NO_ASSERTIONS
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state_reg == ST_RUN))
        else $error("ALU finished outside the run state");

    a_push_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stack_ctrl.push && stack_ctrl.drop))
        else $error("stack pushed and dropped in one cycle");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        stack_ctrl.push |=> (stack_top == $past(operand_reg)))
        else $error("pushed operand missing from X");

    a_refused_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && state_next == ST_FINISH && !stack_ctrl.push)
        |=> $stable(stack_top) && $stable(stack_second))
        else $error("refused step altered the stack");
`endif

endmodule

`default_nettype wire
